// File: sv/cre_pkg.sv
// Shared types and constants for the circle raster engine.
// No dependencies; used by circle_raster_engine.
`default_nettype none

package cre_pkg;

    // Width of every coordinate field on the result channel
    localparam int OUT_W = 14;

    // Input word action codes
    typedef enum logic {
        ACT_START    = 1'b0,
        ACT_CONTINUE = 1'b1
    } t_action;

endpackage

`default_nettype wire

// File: sv/circle_raster_engine.sv
// Circle raster engine: Andres circle stepping with a one-step job register
// and a result register. Depends on cre_pkg.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+--------------------------------------------
//  input   | in  | i_valid / o_stall      | i_action i_center_x i_center_y i_radius_in
//          |     |                        | i_fill_mode
//  result  | out | o_valid / i_stall      | o_span_start_x o_span_end_x o_row_y
//          |     |                        | o_last_of_step o_circle_done
//
// A word that produces a step gives 8 points (outline) or 4 spans (fill): the
// result register emits one point or span per cycle while i_stall is low.
// The next input word is taken in the cycle the step's last result enters the
// result register; a continue word with no circle active makes no step.
// Reset (i_rst_n low, synchronous) drops the job, the pending result and the
// active circle. A stalled result holds; the job register then stalls input.
`default_nettype none

module circle_raster_engine #(
    parameter int COORD_BITS  = 12,
    parameter int RADIUS_BITS = 10
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // input channel
    input  wire                            i_valid,
    output logic                           o_stall,
    input  wire                            i_action,
    input  wire  [COORD_BITS-1:0]          i_center_x,
    input  wire  [COORD_BITS-1:0]          i_center_y,
    input  wire  [RADIUS_BITS-1:0]         i_radius_in,
    input  wire                            i_fill_mode,
    // result channel
    output logic                           o_valid,
    input  wire                            i_stall,
    output logic signed [cre_pkg::OUT_W-1:0] o_span_start_x,
    output logic signed [cre_pkg::OUT_W-1:0] o_span_end_x,
    output logic signed [cre_pkg::OUT_W-1:0] o_row_y,
    output logic                           o_last_of_step,
    output logic                           o_circle_done
);

    // offsets carry a sign (y offset drops to -1 on a zero radius)
    localparam int OW   = RADIUS_BITS + 2;
    localparam int DW   = RADIUS_BITS + 3;
    localparam int MW   = (COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS;
    localparam int CW   = (MW + 3 > cre_pkg::OUT_W) ? MW + 3 : cre_pkg::OUT_W;
    localparam logic signed [DW-1:0] D_ONE = DW'(1);
    localparam logic signed [OW-1:0] O_ONE = OW'(1);

    // circle state
    logic                          r_active;
    logic [COORD_BITS-1:0]         r_cx;
    logic [COORD_BITS-1:0]         r_cy;
    logic [RADIUS_BITS-1:0]        r_radius;
    logic                          r_fill;
    logic signed [OW-1:0]          r_ox;
    logic signed [OW-1:0]          r_oy;
    logic signed [DW-1:0]          r_d;

    // job register: offsets of the step being emitted
    logic                          r_job_valid;
    logic signed [OW-1:0]          r_job_ox;
    logic signed [OW-1:0]          r_job_oy;
    logic                          r_job_done;
    logic [2:0]                    r_idx;

    // result register
    logic                          r_out_valid;
    logic signed [cre_pkg::OUT_W-1:0] r_out_sx;
    logic signed [cre_pkg::OUT_W-1:0] r_out_ex;
    logic signed [cre_pkg::OUT_W-1:0] r_out_y;
    logic                          r_out_last;
    logic                          r_out_done;

    // handshake
    logic out_free;
    logic job_last;
    logic job_move;
    logic in_accept;

    assign out_free  = !r_out_valid || !i_stall;
    assign job_last  = r_fill ? (r_idx == 3'd3) : (r_idx == 3'd7);
    assign job_move  = r_job_valid && out_free;
    assign o_stall   = r_job_valid && !(out_free && job_last);
    assign in_accept = i_valid && !o_stall;

    // step arithmetic on the accepted word
    logic                   ld;
    logic                   emit;
    logic [RADIUS_BITS-1:0] cur_r;
    logic signed [OW-1:0]   cur_ox;
    logic signed [OW-1:0]   cur_oy;
    logic signed [DW-1:0]   cur_d;
    logic signed [DW-1:0]   r_ext;
    logic signed [DW-1:0]   ox_ext;
    logic signed [DW-1:0]   oy_ext;
    logic signed [OW-1:0]   n_ox;
    logic signed [OW-1:0]   n_oy;
    logic signed [DW-1:0]   n_d;
    logic                   n_done;

    always_comb begin
        ld     = (cre_pkg::t_action'(i_action) == cre_pkg::ACT_START);
        emit   = ld || r_active;
        cur_r  = ld ? i_radius_in : r_radius;
        cur_ox = ld ? '0 : r_ox;
        cur_oy = ld ? $signed({2'b00, i_radius_in}) : r_oy;
        r_ext  = $signed({3'b000, cur_r});
        cur_d  = ld ? (r_ext - D_ONE) : r_d;
        ox_ext = $signed({cur_ox[OW-1], cur_ox});
        oy_ext = $signed({cur_oy[OW-1], cur_oy});
        n_ox   = cur_ox;
        n_oy   = cur_oy;
        if (cur_d >= (ox_ext <<< 1)) begin
            n_d  = cur_d - ((ox_ext <<< 1) + D_ONE);
            n_ox = cur_ox + O_ONE;
        end else if (cur_d < ((r_ext - oy_ext) <<< 1)) begin
            n_d  = cur_d + ((oy_ext <<< 1) - D_ONE);
            n_oy = cur_oy - O_ONE;
        end else begin
            n_d  = cur_d + ((oy_ext - ox_ext - D_ONE) <<< 1);
            n_oy = cur_oy - O_ONE;
            n_ox = cur_ox + O_ONE;
        end
        n_done = (n_oy < n_ox);
    end

    // point / span for the current index of the job
    logic                   sel_oy;
    logic                   x_neg;
    logic                   y_neg;
    logic signed [OW-1:0]   xo;
    logic signed [OW-1:0]   yo;
    logic signed [CW-1:0]   cx_w;
    logic signed [CW-1:0]   cy_w;
    logic signed [CW-1:0]   xo_w;
    logic signed [CW-1:0]   yo_w;
    logic signed [CW-1:0]   x_lo;
    logic signed [CW-1:0]   x_hi;
    logic signed [CW-1:0]   y_w;
    logic signed [CW-1:0]   n_sx;
    logic signed [CW-1:0]   n_ex;

    always_comb begin
        if (r_fill) begin
            // spans: oy wide at rows +-ox, ox wide at rows +-oy
            sel_oy = !(r_idx[0] ^ r_idx[1]);
            x_neg  = 1'b1;
            y_neg  = r_idx[1];
        end else begin
            sel_oy = r_idx[0];
            x_neg  = r_idx[1];
            y_neg  = r_idx[2];
        end
        xo   = sel_oy ? r_job_oy : r_job_ox;
        yo   = sel_oy ? r_job_ox : r_job_oy;
        cx_w = $signed({{(CW-COORD_BITS){1'b0}}, r_cx});
        cy_w = $signed({{(CW-COORD_BITS){1'b0}}, r_cy});
        xo_w = $signed({{(CW-OW){xo[OW-1]}}, xo});
        yo_w = $signed({{(CW-OW){yo[OW-1]}}, yo});
        x_lo = cx_w - xo_w;
        x_hi = cx_w + xo_w;
        y_w  = y_neg ? (cy_w - yo_w) : (cy_w + yo_w);
        n_sx = x_neg ? x_lo : x_hi;
        n_ex = r_fill ? x_hi : n_sx;
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_job_valid <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            r_cx        <= '0;
            r_cy        <= '0;
            r_radius    <= '0;
            r_fill      <= 1'b0;
            r_ox        <= '0;
            r_oy        <= '0;
            r_d         <= '0;
        end else begin
            // result register load
            if (out_free) begin
                r_out_valid <= r_job_valid;
            end
            if (job_move) begin
                r_out_sx   <= n_sx[cre_pkg::OUT_W-1:0];
                r_out_ex   <= n_ex[cre_pkg::OUT_W-1:0];
                r_out_y    <= y_w[cre_pkg::OUT_W-1:0];
                r_out_last <= job_last;
                r_out_done <= job_last && r_job_done;
                r_idx      <= job_last ? 3'd0 : r_idx + 3'd1;
            end
            // job register and circle state
            if (in_accept) begin
                r_job_valid <= emit;
                if (ld) begin
                    r_cx     <= i_center_x;
                    r_cy     <= i_center_y;
                    r_radius <= i_radius_in;
                    r_fill   <= i_fill_mode;
                end
                if (emit) begin
                    r_job_ox   <= cur_ox;
                    r_job_oy   <= cur_oy;
                    r_job_done <= n_done;
                    r_ox       <= n_ox;
                    r_oy       <= n_oy;
                    r_d        <= n_d;
                    r_active   <= !n_done;
                end
            end else if (job_move && job_last) begin
                r_job_valid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_span_start_x = r_out_sx;
    assign o_span_end_x   = r_out_ex;
    assign o_row_y        = r_out_y;
    assign o_last_of_step = r_out_last;
    assign o_circle_done  = r_out_done;

endmodule

`default_nettype wire
